// File: src/peft_pkg.sv
package peft_pkg;

    localparam int BANK_SIZE  = 4;
    localparam int STEP_W     = 8;
    localparam int PERIOD_W   = 16;
    localparam int ELAPSED_W  = 17;
    localparam int OPCODE_W   = 3;
    localparam int IDX_W      = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [STEP_W-1:0]   STEP_RESET   = 8'd1;
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd1000;

    typedef enum logic [OPCODE_W-1:0] {
        OP_TICK       = 3'd0,
        OP_SET_FLAG   = 3'd1,
        OP_CLEAR_FLAG = 3'd2,
        OP_READ_FLAG  = 3'd3,
        OP_TEST_CLEAR = 3'd4
    } t_opcode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TICK_STEP = 3'd0,
        CFG_PERIOD_0  = 3'd1,
        CFG_PERIOD_1  = 3'd2,
        CFG_PERIOD_2  = 3'd3,
        CFG_PERIOD_3  = 3'd4
    } t_cfg_idx;

    // result of one pass through the shared add/compare unit
    typedef struct packed {
        logic                 fire;
        logic [ELAPSED_W-1:0] elapsed;
    } t_tick_res;

endpackage

// File: src/peft_tick_unit.sv
module peft_tick_unit (
    input  logic [16:0]         i_elapsed,
    input  logic [7:0]          i_step,
    input  logic [15:0]         i_period,
    output peft_pkg::t_tick_res o_res
);
    import peft_pkg::*;

    logic [ELAPSED_W-1:0] sum;

    // elapsed stays below 65535 + 255, so the 17-bit sum never wraps
    assign sum = i_elapsed + ELAPSED_W'(i_step);

    always_comb begin
        o_res.fire    = (sum >= ELAPSED_W'(i_period));
        o_res.elapsed = o_res.fire ? '0 : sum;
    end

endmodule

// File: src/periodic_event_flag_timers_core.sv
// Flag operations (set, clear, read, test-and-clear): result goes into the result register on transfer.
// Tick: in state S_TICK one timer per cycle goes through the single shared add/compare unit,
// then S_DONE loads the result register once the output is free.
// Throughput: one flag op per cycle unless the output stalls; no new op while a tick runs.
// Reset (synchronous, active low): counters and flags cleared, tick step 1, periods 1000.
module periodic_event_flag_timers_core #(
    parameter int NUM_TIMERS = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_opcode,
    input  logic [1:0]  i_timer_index,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_flag_value,
    output logic [3:0]  o_fired_mask,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    import peft_pkg::*;

    localparam int CNT_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NUM_TIMERS - 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_TICK = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    logic [STEP_W-1:0]    r_step;
    logic [PERIOD_W-1:0]  r_period [BANK_SIZE];
    logic [ELAPSED_W-1:0] r_elapsed [NUM_TIMERS];
    logic [BANK_SIZE-1:0] r_flag, n_flag;
    logic [BANK_SIZE-1:0] r_fired, n_fired;

    logic                 r_out_valid, n_out_valid;
    logic                 r_out_flag, n_out_flag;
    logic [BANK_SIZE-1:0] r_out_fired, n_out_fired;

    logic      in_xfer;
    logic      out_free;
    logic      idx_ok;
    t_tick_res tick_res;

    assign out_free = !r_out_valid || !i_stall;
    assign o_stall  = (r_state != S_IDLE) || !out_free;
    assign in_xfer  = i_valid && !o_stall;
    assign idx_ok   = (int'(i_timer_index) < NUM_TIMERS);

    assign o_valid      = r_out_valid;
    assign o_flag_value = r_out_flag;
    assign o_fired_mask = r_out_fired;

    peft_tick_unit u_tick (
        .i_elapsed (r_elapsed[r_cnt]),
        .i_step    (r_step),
        .i_period  (r_period[IDX_W'(r_cnt)]),
        .o_res     (tick_res)
    );

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_flag      = r_flag;
        n_fired     = r_fired;
        n_out_valid = r_out_valid && i_stall;
        n_out_flag  = r_out_flag;
        n_out_fired = r_out_fired;
        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_out_flag  = 1'b0;
                    n_out_fired = '0;
                    unique case (t_opcode'(i_opcode))
                        OP_TICK: begin
                            n_state = S_TICK;
                            n_cnt   = '0;
                            n_fired = '0;
                        end
                        OP_SET_FLAG: begin
                            if (idx_ok) n_flag[i_timer_index] = 1'b1;
                        end
                        OP_CLEAR_FLAG: begin
                            if (idx_ok) n_flag[i_timer_index] = 1'b0;
                        end
                        OP_READ_FLAG: begin
                            if (idx_ok) n_out_flag = r_flag[i_timer_index];
                        end
                        OP_TEST_CLEAR: begin
                            if (idx_ok) begin
                                n_out_flag             = r_flag[i_timer_index];
                                n_flag[i_timer_index] = 1'b0;
                            end
                        end
                        default: begin
                        end
                    endcase
                    // ticks report from S_DONE
                    n_out_valid = (t_opcode'(i_opcode) != OP_TICK);
                end
            end
            S_TICK: begin
                if (tick_res.fire) begin
                    n_flag[IDX_W'(r_cnt)]  = 1'b1;
                    n_fired[IDX_W'(r_cnt)] = 1'b1;
                end
                if (r_cnt == CNT_LAST) begin
                    n_state = S_DONE;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_flag  = 1'b0;
                    n_out_fired = r_fired;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_flag      <= '0;
            r_fired     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_flag      <= n_flag;
            r_fired     <= n_fired;
            r_out_valid <= n_out_valid;
        end
        r_out_flag  <= n_out_flag;
        r_out_fired <= n_out_fired;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_TIMERS; i++) begin
                r_elapsed[i] <= '0;
            end
        end else if (r_state == S_TICK) begin
            r_elapsed[r_cnt] <= tick_res.elapsed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= STEP_RESET;
            for (int i = 0; i < BANK_SIZE; i++) begin
                r_period[i] <= PERIOD_RESET;
            end
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_TICK_STEP: r_step      <= i_cfg_data[STEP_W-1:0];
                CFG_PERIOD_0:  r_period[0] <= i_cfg_data;
                CFG_PERIOD_1:  r_period[1] <= i_cfg_data;
                CFG_PERIOD_2:  r_period[2] <= i_cfg_data;
                CFG_PERIOD_3:  r_period[3] <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    a_tick_starts_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer && (i_opcode == OP_TICK) |=> (r_state == S_TICK) && (r_cnt == '0))
        else $error("tick transfer did not start the timer walk");

    a_unused_flags_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_flag >> NUM_TIMERS) == '0)
        else $error("flag set for a timer outside the bank");

    a_walk_ends_in_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TICK) && (r_cnt == CNT_LAST) |=> (r_state == S_DONE))
        else $error("timer walk overran the bank");

    for (genvar g = 0; g < NUM_TIMERS; g++) begin : g_chk
        a_elapsed_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
            r_elapsed[g] < ELAPSED_W'(17'd65535))
            else $error("elapsed counter kept a value at or past any period");
    end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import peft_pkg::*;

    localparam int NUM_TIMERS     = 4;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_REPORTS    = 10;

    // opcodes and register indexes the block must ignore
    localparam logic [OPCODE_W-1:0]  OP_SPARE_5   = 3'd5;
    localparam logic [OPCODE_W-1:0]  OP_SPARE_6   = 3'd6;
    localparam logic [OPCODE_W-1:0]  OP_SPARE_7   = 3'd7;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_5  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_6  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_7  = 3'd7;

    typedef struct packed {
        logic [OPCODE_W-1:0] op;
        logic [IDX_W-1:0]    idx;
        logic                flag;
        logic [3:0]          fired;
    } t_timer_result;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  o_stall;
    logic [OPCODE_W-1:0]   i_opcode;
    logic [IDX_W-1:0]      i_timer_index;
    logic                  o_valid;
    logic                  i_stall;
    logic                  o_flag_value;
    logic [3:0]            o_fired_mask;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    // shadow copy of the timer bank
    logic [STEP_W-1:0]    bank_step;
    logic [PERIOD_W-1:0]  bank_period  [BANK_SIZE];
    logic [ELAPSED_W-1:0] bank_elapsed [BANK_SIZE];
    logic                 bank_flag    [BANK_SIZE];

    t_timer_result pending_results [$];
    int            error_count  = 0;
    int            quiet_cycles = 0;
    int            stall_left   = 0;
    bit            idle_on      = 1'b1;

    periodic_event_flag_timers_core #(
        .NUM_TIMERS(NUM_TIMERS)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_opcode      (i_opcode),
        .i_timer_index (i_timer_index),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_flag_value  (o_flag_value),
        .o_fired_mask  (o_fired_mask),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    function automatic void reset_bank();
        bank_step = STEP_RESET;
        for (int t = 0; t < BANK_SIZE; t++) begin
            bank_period[t]  = PERIOD_RESET;
            bank_elapsed[t] = '0;
            bank_flag[t]    = 1'b0;
        end
    endfunction

    function automatic void apply_register(input logic [CFG_IDX_W-1:0]  index,
                                           input logic [CFG_DATA_W-1:0] data);
        case (index)
            CFG_TICK_STEP: bank_step = data[STEP_W-1:0];
            CFG_PERIOD_0, CFG_PERIOD_1, CFG_PERIOD_2, CFG_PERIOD_3:
                bank_period[IDX_W'(index - CFG_PERIOD_0)] = data[PERIOD_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic t_timer_result predict_timer_bank(input logic [OPCODE_W-1:0] op,
                                                         input logic [IDX_W-1:0]    idx);
        t_timer_result        res;
        logic [ELAPSED_W-1:0] sum;
        bit                   ok;
        res     = '0;
        res.op  = op;
        res.idx = idx;
        ok      = idx < NUM_TIMERS;
        case (op)
            OP_TICK: begin
                for (int t = 0; t < BANK_SIZE; t++) begin
                    if (t < NUM_TIMERS) begin
                        sum = bank_elapsed[t] + bank_step;
                        if (sum >= bank_period[t]) begin
                            bank_flag[t]    = 1'b1;
                            sum             = '0;
                            res.fired[t]    = 1'b1;
                        end
                        bank_elapsed[t] = sum;
                    end
                end
            end
            OP_SET_FLAG: if (ok) bank_flag[idx] = 1'b1;
            OP_CLEAR_FLAG: if (ok) bank_flag[idx] = 1'b0;
            OP_READ_FLAG: if (ok) res.flag = bank_flag[idx];
            OP_TEST_CLEAR: begin
                if (ok) begin
                    res.flag       = bank_flag[idx];
                    bank_flag[idx] = 1'b0;
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    task automatic log_mismatch(input string what, input t_timer_result want,
                                input logic got_flag, input logic [3:0] got_fired);
        error_count++;
        if (error_count <= MAX_REPORTS) begin
            $display("%0t %s: op %0d idx %0d expected flag %b mask %b, got flag %b mask %b",
                     $time, what, want.op, want.idx, want.flag, want.fired,
                     got_flag, got_fired);
        end
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_timer_result want;
        if (i_rst_n && o_valid === 1'b1 && !i_stall) begin
            if (pending_results.size() == 0) begin
                log_mismatch("unexpected transfer", '0, o_flag_value, o_fired_mask);
            end else begin
                want = pending_results.pop_front();
                if (o_flag_value !== want.flag || o_fired_mask !== want.fired) begin
                    log_mismatch("mismatch", want, o_flag_value, o_fired_mask);
                end
            end
        end
    end

    // receiver backpressure in random bursts
    always @(posedge i_clk) begin
        if (!idle_on || !i_rst_n) begin
            stall_left = 0;
            i_stall   <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left = stall_left - 1;
            i_stall   <= 1'b1;
        end else if ($urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(0, 16);
            i_stall   <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // watchdog: too long without any transfer
    always @(posedge i_clk) begin
        if ((i_valid && o_stall === 1'b0) || (o_valid === 1'b1 && !i_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("testbench: errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic issue_op(input logic [OPCODE_W-1:0] op, input logic [IDX_W-1:0] idx);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_opcode      <= op;
        i_timer_index <= idx;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        pending_results.push_back(predict_timer_bank(op, idx));
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0]  index,
                                  input logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        apply_register(index, data);
        @(posedge i_clk);
    endtask

    task automatic write_periods(input logic [PERIOD_W-1:0] p0, input logic [PERIOD_W-1:0] p1,
                                 input logic [PERIOD_W-1:0] p2, input logic [PERIOD_W-1:0] p3);
        write_register(CFG_PERIOD_0, p0);
        write_register(CFG_PERIOD_1, p1);
        write_register(CFG_PERIOD_2, p2);
        write_register(CFG_PERIOD_3, p3);
    endtask

    task automatic random_item();
        logic [OPCODE_W-1:0] op;
        int                  sel;
        sel = $urandom_range(0, 19);
        if (sel < 9)
            op = OP_TICK;
        else if (sel < 19)
            op = OPCODE_W'(OP_SET_FLAG + $urandom_range(0, 3));
        else
            op = OPCODE_W'($urandom_range(0, 7));
        issue_op(op, IDX_W'($urandom_range(0, 3)));
    endtask

    function automatic logic [PERIOD_W-1:0] pick_period(input int step);
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return PERIOD_W'($urandom_range(0, 65535));
            default: return PERIOD_W'($urandom_range(0, 4 * step + 8));
        endcase
    endfunction

    // reset values: step 1, period 1000, all flags clear
    task automatic test_defaults();
        issue_op(OP_READ_FLAG, 0);
        issue_op(OP_TEST_CLEAR, 3);
        issue_op(OP_TICK, 2);
        issue_op(OP_TICK, 1);
    endtask

    task automatic test_flag_ops();
        issue_op(OP_SET_FLAG, 0);
        issue_op(OP_SET_FLAG, 3);
        issue_op(OP_READ_FLAG, 0);
        issue_op(OP_READ_FLAG, 3);
        issue_op(OP_TEST_CLEAR, 0);
        issue_op(OP_TEST_CLEAR, 0);
        issue_op(OP_CLEAR_FLAG, 3);
        issue_op(OP_READ_FLAG, 3);
        issue_op(OP_SET_FLAG, 1);
        issue_op(OP_SET_FLAG, 2);
        issue_op(OP_CLEAR_FLAG, 2);
        // unused opcodes leave the flags alone
        issue_op(OP_SPARE_5, 1);
        issue_op(OP_SPARE_6, 2);
        issue_op(OP_SPARE_7, 3);
        issue_op(OP_READ_FLAG, 1);
    endtask

    // largest step, zero / one / equal / full-scale periods
    task automatic test_extremes();
        drain_results();
        write_register(CFG_TICK_STEP, {8'($urandom), 8'hFF});
        write_periods(16'd0, 16'd1, 16'd255, 16'hFFFF);
        issue_op(OP_TICK, 0);
        issue_op(OP_TICK, 3);
        issue_op(OP_TEST_CLEAR, 2);
    endtask

    // zero step: nothing counts, zero period still fires; spare registers ignored
    task automatic test_step_zero();
        drain_results();
        write_register(CFG_TICK_STEP, 16'hFF00);
        write_periods(16'd0, 16'd7, 16'hFFFF, 16'd1);
        write_register(CFG_SPARE_5, 16'hFFFF);
        write_register(CFG_SPARE_6, 16'h0001);
        write_register(CFG_SPARE_7, 16'h8000);
        issue_op(OP_TICK, 0);
        issue_op(OP_TICK, 1);
    endtask

    // full-scale periods need about 257 ticks at the largest step
    task automatic test_long_count();
        drain_results();
        write_register(CFG_TICK_STEP, {8'($urandom), 8'hFF});
        write_periods(16'hFFFF, 16'hFFFE, 16'd3, 16'd0);
        for (int n = 0; n < 270; n++) begin
            if ($urandom_range(0, 9) == 0)
                issue_op(OPCODE_W'(OP_SET_FLAG + $urandom_range(0, 3)),
                         IDX_W'($urandom_range(0, 3)));
            else
                issue_op(OP_TICK, IDX_W'($urandom_range(0, 3)));
        end
    endtask

    task automatic test_random_phases(input int phases, input int items);
        int step;
        for (int p = 0; p < phases; p++) begin
            drain_results();
            case ($urandom_range(0, 5))
                0:       step = 0;
                1:       step = 255;
                2:       step = 1;
                default: step = $urandom_range(1, 255);
            endcase
            write_register(CFG_TICK_STEP, {8'($urandom), 8'(step)});
            write_periods(pick_period(step), pick_period(step),
                          pick_period(step), pick_period(step));
            if ($urandom_range(0, 2) == 0)
                write_register(CFG_IDX_W'(CFG_SPARE_5 + $urandom_range(0, 2)),
                               16'($urandom));
            for (int n = 0; n < items; n++) random_item();
        end
    endtask

    task automatic test_back_to_back();
        idle_on = 1'b0;
        for (int n = 0; n < 40; n++) random_item();
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_opcode      = OP_TICK;
        i_timer_index = '0;
        i_stall       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = CFG_TICK_STEP;
        i_cfg_data    = '0;
        reset_bank();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_defaults();
        test_flag_ops();
        test_extremes();
        test_step_zero();
        test_long_count();
        test_random_phases(5, 40);
        test_back_to_back();

        drain_results();
        repeat (NUM_TIMERS + 4) @(posedge i_clk);
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule
